### design/eight_pin_input_debouncer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the eight-pin input debouncer
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef EIGHT_PIN_INPUT_DEBOUNCER_MACROS_SVH
`define EIGHT_PIN_INPUT_DEBOUNCER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define DEB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("debouncer assertion failed");

// Check that cons holds in the cycle after ante.
`define DEB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("debouncer assertion failed");

`endif

### design/deb8_pkg.sv
// ----------------------------------------------------------------------------
// Debouncer package
// Widths, defaults and shared types of the eight-pin input debouncer.
// ----------------------------------------------------------------------------
package deb8_pkg;

	// Default sizing
	localparam int DEB_PIN_COUNT   = 8;
	localparam int DEB_COUNT_WIDTH = 16;

	// Threshold registers
	localparam int          THR_W     = 16;
	localparam int          THR_REGS  = 8;
	localparam int          IDX_W     = 3;
	localparam logic [15:0] THR_RESET = 16'd10;

	// Stream payloads
	localparam int SAMPLE_W    = 8;
	localparam int OUT_PINS    = 8;
	localparam int OUT_TDATA_W = 24;

	// Per-lane control for one accepted item
	typedef struct packed {
		logic acc;     // item accepted this cycle
		logic sample;  // raw level of this pin
		logic stable;  // current debounced level of this pin
	} lane_in_t;

endpackage

### design/deb8_lane.sv
// ----------------------------------------------------------------------------
// Debouncer lane
// Mismatch counter of one pin; flags the tick on which a new level is taken.
// ----------------------------------------------------------------------------
module deb8_lane #(
	parameter int COUNT_WIDTH = deb8_pkg::DEB_COUNT_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  deb8_pkg::lane_in_t       ctl,
	input  logic [deb8_pkg::THR_W-1:0] threshold,
	output logic                     flip
);
	import deb8_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic                   mismatch;

	// Saturating increment and threshold match
	assign mismatch  = ctl.sample ^ ctl.stable;
	assign count_inc = (count_q == {COUNT_WIDTH{1'b1}}) ? count_q
	                   : count_q + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
	assign flip      = mismatch && (CMP_W'(count_inc) == CMP_W'(threshold));

	// Clear on a matching sample, advance on a differing one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.acc) begin
			if (mismatch) begin
				count_q <= count_inc;
			end else begin
				count_q <= '0;
			end
		end
	end

endmodule

### design/deb8_merge.sv
// ----------------------------------------------------------------------------
// Debouncer merge stage
// Combines lane flips into the stable levels and buffers result items.
// ----------------------------------------------------------------------------
`include "eight_pin_input_debouncer_macros.svh"

module deb8_merge #(
	parameter int PIN_COUNT = deb8_pkg::DEB_PIN_COUNT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              acc,
	input  logic [PIN_COUNT-1:0]              flips,
	output logic [PIN_COUNT-1:0]              stable,
	output logic                              s_tready,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [deb8_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import deb8_pkg::*;

	logic [PIN_COUNT-1:0]   stable_q;
	logic [OUT_PINS-1:0]    stable_vis;
	logic [OUT_PINS-1:0]    changed_vis;
	logic [OUT_TDATA_W-1:0] result;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [OUT_TDATA_W-1:0] skid_data_q;
	logic                   out_vld_q;
	logic                   skid_vld_q;
	logic                   take;

	assign stable = stable_q;

	// Map lane results onto the eight visible pins
	for (genvar j = 0; j < OUT_PINS; j++) begin : g_vis
		if (j < PIN_COUNT) begin : g_on
			assign stable_vis[j]  = stable_q[j] ^ flips[j];
			assign changed_vis[j] = flips[j];
		end else begin : g_off
			assign stable_vis[j]  = 1'b0;
			assign changed_vis[j] = 1'b0;
		end
	end

	// Pack: stable_pins, changed_mask, any_change
	assign result = {7'd0, |changed_vis, changed_vis, stable_vis};

	// Update the debounced levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= '0;
		end else if (acc) begin
			stable_q <= stable_q ^ flips;
		end
	end

	// Output register with a skid stage
	assign take     = out_vld_q && m_tready;
	assign s_tready = !skid_vld_q;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (take) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= acc;
			end
		end else if (acc) begin
			if (!out_vld_q) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_vld_q) begin
				out_data_q <= skid_data_q;
			end else begin
				out_data_q <= result;
			end
		end else if (acc) begin
			if (!out_vld_q) begin
				out_data_q <= result;
			end else begin
				skid_data_q <= result;
			end
		end
	end

	// Skid holds an item only behind a held output item
	`DEB_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_vld_q, out_vld_q)
	// No item is accepted while the skid stage is full
	`DEB_ASSERT_SAME(a_no_acc_full, clk, arst_n, skid_vld_q, !acc)
	// Draining the skid keeps an item at the output
	`DEB_ASSERT_NEXT(a_skid_drain, clk, arst_n, take && skid_vld_q, out_vld_q && !skid_vld_q)
	// Change flag agrees with the change mask
	`DEB_ASSERT_SAME(a_any_flag, clk, arst_n, out_vld_q,
		out_data_q[2*OUT_PINS] == (out_data_q[2*OUT_PINS-1:OUT_PINS] != '0))

endmodule

### design/eight_pin_input_debouncer.sv
// ----------------------------------------------------------------------------
// Eight-pin input debouncer
// Per-pin counter debouncer with programmable thresholds.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one item per timer tick; s_tdata[7:0] is the raw pin sample.
//   m_* channel: one result item per input item, in order.
//   wr_en/wr_index/wr_data: write threshold_pin<wr_index> (low 16 bits);
//   write only while no item is in flight.
// Each pin runs its own lane: a saturating mismatch counter that clears on a
// matching sample and takes the new level on the tick its count equals the
// pin threshold. A threshold of zero never accepts a change.
// Each result is registered in the output register or the skid stage.
// Throughput: one item per cycle unless stalled; all lanes update together.
// Stall: an output register and a one-item skid stage let one more item be
// taken while the receiver holds off; s_tready drops when both are full.
// Reset: stable levels and counters clear, thresholds return to 10, and both
// output buffers empty.
// ----------------------------------------------------------------------------
module eight_pin_input_debouncer #(
	parameter int PIN_COUNT   = deb8_pkg::DEB_PIN_COUNT,
	parameter int COUNT_WIDTH = deb8_pkg::DEB_COUNT_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [deb8_pkg::SAMPLE_W-1:0]    s_tdata,   // [7:0] raw_pins
	// Output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [deb8_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] stable_pins,
	                                                    // [15:8] changed_mask,
	                                                    // [16] any_change
	// Configuration write port
	input  logic                             wr_en,
	input  logic [deb8_pkg::IDX_W-1:0]       wr_index,
	input  logic [deb8_pkg::THR_W-1:0]       wr_data
);
	import deb8_pkg::*;

	logic [THR_W-1:0]     thr_q [PIN_COUNT];
	logic [PIN_COUNT-1:0] sample;
	logic [PIN_COUNT-1:0] stable;
	logic [PIN_COUNT-1:0] flips;
	logic                 acc;

	assign acc = s_tvalid && s_tready;

	for (genvar i = 0; i < PIN_COUNT; i++) begin : g_pin
		lane_in_t ctl;

		// Pins past the input word sample low
		if (i < SAMPLE_W) begin : g_in
			assign sample[i] = s_tdata[i];
		end else begin : g_zero
			assign sample[i] = 1'b0;
		end

		// Threshold register; pins past the register list keep the reset value
		if (i < THR_REGS) begin : g_thr
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					thr_q[i] <= THR_RESET;
				end else if (wr_en && (wr_index == IDX_W'(i))) begin
					thr_q[i] <= wr_data;
				end
			end
		end else begin : g_thr_fix
			assign thr_q[i] = THR_RESET;
		end

		assign ctl.acc    = acc;
		assign ctl.sample = sample[i];
		assign ctl.stable = stable[i];

		deb8_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.threshold(thr_q[i]),
			.flip     (flips[i])
		);
	end

	// Merge lane results and buffer the result items
	deb8_merge #(
		.PIN_COUNT(PIN_COUNT)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.flips   (flips),
		.stable  (stable),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
